>>> hw/rtl/dpsp_pkg.sv
// Shared types, register indexes and the decimal split for the dual PWM setpoint panel.
`timescale 1ns / 1ps

package dpsp_pkg;

    localparam int unsigned SETTING_W = 7;
    localparam int unsigned DELAY_W   = 15;
    localparam int unsigned HOLD_W    = 16;
    localparam int unsigned FRAME_W   = 8;
    localparam int unsigned DIGIT_W   = 4;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 15;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_SETTING  = 2'd0,
        CFG_FIRST_DELAY  = 2'd1,
        CFG_REPEAT_INTVL = 2'd2,
        CFG_FRAMES_DIGIT = 2'd3
    } cfg_index_t;

    localparam logic [SETTING_W-1:0] MAX_SETTING_RST  = 7'd99;
    localparam logic [DELAY_W-1:0]   FIRST_DELAY_RST  = 15'd800;
    localparam logic [DELAY_W-1:0]   REPEAT_INTVL_RST = 15'd300;
    localparam logic [FRAME_W-1:0]   FRAMES_DIGIT_RST = 8'd4;

    typedef struct packed {
        logic [SETTING_W-1:0] max_setting;
        logic [DELAY_W-1:0]   first_delay;
        logic [DELAY_W-1:0]   repeat_intvl;
        logic [FRAME_W-1:0]   frames_digit;
    } cfg_t;

    typedef struct packed {
        logic [SETTING_W-1:0] setting_one;
        logic [SETTING_W-1:0] setting_two;
        logic                 channel;
        logic [HOLD_W-1:0]    hold_count;
        logic                 plus_held;
        logic                 minus_held;
        logic                 select_held;
        logic [FRAME_W-1:0]   frame_count;
        logic                 digit;
    } panel_state_t;

    typedef struct packed {
        logic [SETTING_W-1:0] duty_first;
        logic [SETTING_W-1:0] duty_second;
        logic                 selected_channel;
        logic [DIGIT_W-1:0]   digit_value;
        logic                 digit_position;
        logic                 digit_strobe;
        logic                 save_first;
        logic                 save_second;
    } result_t;

    // Tens of a 7-bit value: multiply by 205/2048, exact for every value below 128.
    function automatic logic [DIGIT_W-1:0] tens_of(input logic [SETTING_W-1:0] v);
        logic [14:0] prod;
        prod = {8'd0, v} * 15'd205;
        return prod[14:11];
    endfunction

    function automatic logic [DIGIT_W-1:0] units_of(input logic [SETTING_W-1:0] v);
        logic [SETTING_W-1:0] tens_x10;
        logic [SETTING_W-1:0] rem;
        tens_x10 = {3'd0, tens_of(v)} * 7'd10;
        rem      = v - tens_x10;
        return rem[DIGIT_W-1:0];
    endfunction

endpackage

>>> hw/rtl/dpsp_step.sv
// Next-state and result logic for one display tick of the setpoint panel.
`timescale 1ns / 1ps

module dpsp_step (
    input  dpsp_pkg::panel_state_t st,
    input  dpsp_pkg::cfg_t         cfg,
    input  logic                   plus_level,
    input  logic                   minus_level,
    input  logic                   select_level,
    output dpsp_pkg::panel_state_t st_next,
    output dpsp_pkg::result_t      res
);

    logic [dpsp_pkg::SETTING_W-1:0] cur;
    logic [dpsp_pkg::HOLD_W-1:0]    hold_inc;
    logic [dpsp_pkg::HOLD_W-1:0]    hold_first;
    logic [dpsp_pkg::HOLD_W-1:0]    hold_wrap;
    logic                           do_nudge;
    logic                           nudge_up;
    logic                           save;
    logic [dpsp_pkg::SETTING_W-1:0] nudged;

    assign cur        = st.channel ? st.setting_two : st.setting_one;
    assign hold_inc   = st.hold_count + 16'd1;
    assign hold_first = {1'b0, cfg.first_delay};
    assign hold_wrap  = {1'b0, cfg.first_delay} + {1'b0, cfg.repeat_intvl};

    always_comb
    begin
        if (nudge_up)
        begin
            nudged = (cur < cfg.max_setting) ? cur + 7'd1 : cur;
        end
        else
        begin
            nudged = (cur != '0) ? cur - 7'd1 : cur;
        end
    end

    always_comb
    begin
        st_next  = st;
        res      = '0;
        do_nudge = 1'b0;
        nudge_up = 1'b0;
        save     = 1'b0;

        // The readout works on the settings and channel from before this tick.
        if (st.frame_count > cfg.frames_digit)
        begin
            st_next.frame_count = 8'd1;
            st_next.digit       = ~st.digit;
            res.digit_value     = st.digit ? dpsp_pkg::units_of(cur)
                                           : dpsp_pkg::tens_of(cur);
            res.digit_strobe    = 1'b1;
        end
        else
        begin
            st_next.frame_count = st.frame_count + 8'd1;
        end

        if (plus_level && !st.plus_held)
        begin
            st_next.plus_held = 1'b1;
            do_nudge          = 1'b1;
            nudge_up          = 1'b1;
        end
        else if (plus_level && st.plus_held)
        begin
            nudge_up           = 1'b1;
            st_next.hold_count = hold_inc;
            if (hold_inc == hold_first)
            begin
                do_nudge = 1'b1;
            end
            else if (hold_inc == hold_wrap)
            begin
                st_next.hold_count = hold_first;
                do_nudge           = 1'b1;
            end
        end
        else if (!plus_level && st.plus_held)
        begin
            st_next.plus_held  = 1'b0;
            st_next.hold_count = '0;
            save               = 1'b1;
        end
        else if (minus_level && !st.minus_held)
        begin
            st_next.minus_held = 1'b1;
            do_nudge           = 1'b1;
        end
        else if (minus_level && st.minus_held)
        begin
            st_next.hold_count = hold_inc;
            if (hold_inc == hold_first)
            begin
                do_nudge = 1'b1;
            end
            else if (hold_inc == hold_wrap)
            begin
                st_next.hold_count = hold_first;
                do_nudge           = 1'b1;
            end
        end
        else if (!minus_level && st.minus_held)
        begin
            st_next.minus_held = 1'b0;
            st_next.hold_count = '0;
            save               = 1'b1;
        end
        else if (select_level && !st.select_held)
        begin
            st_next.select_held = 1'b1;
            st_next.channel     = ~st.channel;
        end
        else if (!select_level && st.select_held)
        begin
            st_next.select_held = 1'b0;
        end

        if (do_nudge)
        begin
            if (st.channel)
            begin
                st_next.setting_two = nudged;
            end
            else
            begin
                st_next.setting_one = nudged;
            end
        end

        res.duty_first       = st_next.setting_one;
        res.duty_second      = st_next.setting_two;
        res.selected_channel = st_next.channel;
        res.digit_position   = st_next.digit;
        res.save_first       = save & ~st.channel;
        res.save_second      = save & st.channel;
    end

endmodule

>>> hw/rtl/dual_pwm_setpoint_panel.sv
// Top level of the dual PWM setpoint panel: button ticks in, settings and readout out.
// A word is registered in the input register on acceptance, and its result is registered in
// the result register once that register can take it, so a low out_ready can hold it back.
// Throughput: one word per cycle while out_ready is high; the single pass of step logic sets that rate.
// Reset (rst_n, asynchronous, active low) clears both settings, the channel, all counters
// and flags, and loads the configuration defaults 99, 800, 300 and 4.
`timescale 1ns / 1ps

module dual_pwm_setpoint_panel (
    input  logic                             clk,
    input  logic                             rst_n,
    // Configuration write port
    input  logic                             cfg_wr_en,
    input  logic [dpsp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dpsp_pkg::CFG_DAT_W-1:0]   cfg_data,
    // Input channel: one word per display tick
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             plus_level,
    input  logic                             minus_level,
    input  logic                             select_level,
    // Result channel
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [dpsp_pkg::SETTING_W-1:0]   duty_first,
    output logic [dpsp_pkg::SETTING_W-1:0]   duty_second,
    output logic                             selected_channel,
    output logic [dpsp_pkg::DIGIT_W-1:0]     digit_value,
    output logic                             digit_position,
    output logic                             digit_strobe,
    output logic                             save_first,
    output logic                             save_second
);

    // Configuration registers.
    dpsp_pkg::cfg_t         cfg_reg;

    // Panel state, advanced once for every word that passes the step logic.
    dpsp_pkg::panel_state_t state_reg;
    dpsp_pkg::panel_state_t state_next;

    // Input register: the button levels of the word waiting for the step logic.
    logic                   in_vld_reg;
    logic                   plus_reg;
    logic                   minus_reg;
    logic                   select_reg;

    // Result register.
    logic                   out_vld_reg;
    dpsp_pkg::result_t      res_reg;
    dpsp_pkg::result_t      res_next;

    logic                   advance;

    // The result register can take a new word when it is empty or being emptied this
    // cycle; the input register then drains into it, so both stages move together.
    assign advance  = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready = !in_vld_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_setting  <= dpsp_pkg::MAX_SETTING_RST;
            cfg_reg.first_delay  <= dpsp_pkg::FIRST_DELAY_RST;
            cfg_reg.repeat_intvl <= dpsp_pkg::REPEAT_INTVL_RST;
            cfg_reg.frames_digit <= dpsp_pkg::FRAMES_DIGIT_RST;
        end
        else if (cfg_wr_en)
        begin
            case (dpsp_pkg::cfg_index_t'(cfg_index))
                dpsp_pkg::CFG_MAX_SETTING:
                    cfg_reg.max_setting  <= cfg_data[dpsp_pkg::SETTING_W-1:0];
                dpsp_pkg::CFG_FIRST_DELAY:
                    cfg_reg.first_delay  <= cfg_data[dpsp_pkg::DELAY_W-1:0];
                dpsp_pkg::CFG_REPEAT_INTVL:
                    cfg_reg.repeat_intvl <= cfg_data[dpsp_pkg::DELAY_W-1:0];
                dpsp_pkg::CFG_FRAMES_DIGIT:
                    cfg_reg.frames_digit <= cfg_data[dpsp_pkg::FRAME_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Input stage: valid flag is reset, the captured levels are plain payload.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            plus_reg   <= plus_level;
            minus_reg  <= minus_level;
            select_reg <= select_level;
        end
    end

    dpsp_step u_step (
        .st           (state_reg),
        .cfg          (cfg_reg),
        .plus_level   (plus_reg),
        .minus_level  (minus_reg),
        .select_level (select_reg),
        .st_next      (state_next),
        .res          (res_next)
    );

    // State moves only when a word leaves the input register; result valid is set then and cleared when taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                state_reg <= state_next;
            end
            if (advance)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid        = out_vld_reg;
    assign duty_first       = res_reg.duty_first;
    assign duty_second      = res_reg.duty_second;
    assign selected_channel = res_reg.selected_channel;
    assign digit_value      = res_reg.digit_value;
    assign digit_position   = res_reg.digit_position;
    assign digit_strobe     = res_reg.digit_strobe;
    assign save_first       = res_reg.save_first;
    assign save_second      = res_reg.save_second;

endmodule

>>> tb/tb_dual_pwm_setpoint_panel.sv
// Self-checking testbench for the dual PWM setpoint panel, with its own predictor and scoreboard.
`timescale 1ns / 1ps

module tb_dual_pwm_setpoint_panel;

    // ------------------------------------------------------------------
    // Scoreboard. It keeps a private copy of the panel: both settings, the
    // channel, the shared hold counter, the three held flags, the frame
    // counter and the digit select, plus the four configuration registers.
    // Every accepted input word advances that copy by one display tick and
    // queues the readout the block ought to return for it.
    // ------------------------------------------------------------------
    class setpoint_scoreboard;

        logic [dpsp_pkg::SETTING_W-1:0] limit_v;
        logic [dpsp_pkg::DELAY_W-1:0]   first_delay_v;
        logic [dpsp_pkg::DELAY_W-1:0]   repeat_v;
        logic [dpsp_pkg::FRAME_W-1:0]   frames_v;

        logic [dpsp_pkg::SETTING_W-1:0] set_a;
        logic [dpsp_pkg::SETTING_W-1:0] set_b;
        logic                           chan;
        logic [dpsp_pkg::HOLD_W-1:0]    hold;
        logic                           plus_down;
        logic                           minus_down;
        logic                           select_down;
        logic [dpsp_pkg::FRAME_W-1:0]   frame;
        logic                           digit;

        dpsp_pkg::result_t              readout_q[$];
        int unsigned                    mismatches;

        function new();
            limit_v       = dpsp_pkg::MAX_SETTING_RST;
            first_delay_v = dpsp_pkg::FIRST_DELAY_RST;
            repeat_v      = dpsp_pkg::REPEAT_INTVL_RST;
            frames_v      = dpsp_pkg::FRAMES_DIGIT_RST;
            set_a         = '0;
            set_b         = '0;
            chan          = 1'b0;
            hold          = '0;
            plus_down     = 1'b0;
            minus_down    = 1'b0;
            select_down   = 1'b0;
            frame         = '0;
            digit         = 1'b0;
            mismatches    = 0;
        endfunction

        // Registers take only as many low bits of the data as they are wide.
        function void set_reg(dpsp_pkg::cfg_index_t idx, logic [dpsp_pkg::CFG_DAT_W-1:0] val);
            case (idx)
                dpsp_pkg::CFG_MAX_SETTING:  limit_v       = val[dpsp_pkg::SETTING_W-1:0];
                dpsp_pkg::CFG_FIRST_DELAY:  first_delay_v = val[dpsp_pkg::DELAY_W-1:0];
                dpsp_pkg::CFG_REPEAT_INTVL: repeat_v      = val[dpsp_pkg::DELAY_W-1:0];
                dpsp_pkg::CFG_FRAMES_DIGIT: frames_v      = val[dpsp_pkg::FRAME_W-1:0];
                default: ;
            endcase
        endfunction

        // One saturating step of the selected setting. A setting that sits
        // above a lowered limit refuses increments but still decrements.
        function void step_setting(bit up);
            logic [dpsp_pkg::SETTING_W-1:0] cur;
            cur = chan ? set_b : set_a;
            if (up) begin
                if (cur < limit_v)
                    cur = cur + 1'b1;
            end
            else if (cur > 0) begin
                cur = cur - 1'b1;
            end
            if (chan)
                set_b = cur;
            else
                set_a = cur;
        endfunction

        // Auto-repeat while a button stays down; the counter is shared by
        // plus and minus and wraps from first delay plus repeat back to the first delay.
        function void advance_hold(bit up);
            logic [dpsp_pkg::HOLD_W-1:0] wrap_at;
            wrap_at = {1'b0, first_delay_v} + {1'b0, repeat_v};
            hold    = hold + 1'b1;
            if (hold == {1'b0, first_delay_v}) begin
                step_setting(up);
            end
            else if (hold == wrap_at) begin
                hold = {1'b0, first_delay_v};
                step_setting(up);
            end
        endfunction

        function void note_tick(bit plus_b, bit minus_b, bit select_b);
            dpsp_pkg::result_t              r;
            logic [dpsp_pkg::SETTING_W-1:0] cur;
            r = '0;

            // The readout looks at the settings and channel from before
            // this tick's buttons are handled.
            if (frame > frames_v) begin
                cur   = chan ? set_b : set_a;
                frame = 8'd1;
                if (!digit) begin
                    digit         = 1'b1;
                    r.digit_value = 4'(cur / 7'd10);
                end
                else begin
                    digit         = 1'b0;
                    r.digit_value = 4'(cur % 7'd10);
                end
                r.digit_strobe = 1'b1;
            end
            else begin
                frame = frame + 1'b1;
            end

            // Button priority: plus, then minus, then the channel button.
            if (plus_b && !plus_down) begin
                plus_down = 1'b1;
                step_setting(1'b1);
            end
            else if (plus_b && plus_down) begin
                advance_hold(1'b1);
            end
            else if (!plus_b && plus_down) begin
                plus_down = 1'b0;
                hold      = '0;
                if (chan) r.save_second = 1'b1; else r.save_first = 1'b1;
            end
            else if (minus_b && !minus_down) begin
                minus_down = 1'b1;
                step_setting(1'b0);
            end
            else if (minus_b && minus_down) begin
                advance_hold(1'b0);
            end
            else if (!minus_b && minus_down) begin
                minus_down = 1'b0;
                hold       = '0;
                if (chan) r.save_second = 1'b1; else r.save_first = 1'b1;
            end
            else if (select_b && !select_down) begin
                select_down = 1'b1;
                chan        = ~chan;
            end
            else if (!select_b && select_down) begin
                select_down = 1'b0;
            end

            r.duty_first       = set_a;
            r.duty_second      = set_b;
            r.selected_channel = chan;
            r.digit_position   = digit;
            readout_q.push_back(r);
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            mismatches++;
        endtask

        task compare_field(string name, logic [7:0] got, logic [7:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
        endtask

        task check_readout(dpsp_pkg::result_t got);
            dpsp_pkg::result_t want;
            if (readout_q.size() == 0) begin
                report_mismatch("readout word with nothing expected");
                return;
            end
            want = readout_q.pop_front();
            compare_field("duty_first",       got.duty_first,       want.duty_first);
            compare_field("duty_second",      got.duty_second,      want.duty_second);
            compare_field("selected_channel", got.selected_channel, want.selected_channel);
            compare_field("digit_value",      got.digit_value,      want.digit_value);
            compare_field("digit_position",   got.digit_position,   want.digit_position);
            compare_field("digit_strobe",     got.digit_strobe,     want.digit_strobe);
            compare_field("save_first",       got.save_first,       want.save_first);
            compare_field("save_second",      got.save_second,      want.save_second);
        endtask

    endclass

    // ------------------------------------------------------------------
    // Block connections.
    // ------------------------------------------------------------------
    logic                           clk;
    logic                           rst_n;
    logic                           cfg_wr_en;
    logic [dpsp_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [dpsp_pkg::CFG_DAT_W-1:0] cfg_data;
    logic                           in_valid;
    logic                           in_ready;
    logic                           plus_level;
    logic                           minus_level;
    logic                           select_level;
    logic                           out_valid;
    logic                           out_ready;
    logic [dpsp_pkg::SETTING_W-1:0] duty_first;
    logic [dpsp_pkg::SETTING_W-1:0] duty_second;
    logic                           selected_channel;
    logic [dpsp_pkg::DIGIT_W-1:0]   digit_value;
    logic                           digit_position;
    logic                           digit_strobe;
    logic                           save_first;
    logic                           save_second;

    dual_pwm_setpoint_panel u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .plus_level       (plus_level),
        .minus_level      (minus_level),
        .select_level     (select_level),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .duty_first       (duty_first),
        .duty_second      (duty_second),
        .selected_channel (selected_channel),
        .digit_value      (digit_value),
        .digit_position   (digit_position),
        .digit_strobe     (digit_strobe),
        .save_first       (save_first),
        .save_second      (save_second)
    );

    setpoint_scoreboard panel_sb = new();

    // Counters shared by the sender, the receiver and the main sequence.
    int unsigned ticks_sent;
    int unsigned readouts_seen;
    int unsigned send_calm;
    // Set for the closing part of the run, where neither side idles.
    bit          quiet_run;

    // Free-running 50 MHz clock.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Watchdog. A correct run needs well under a tenth of this time, even with
    // every word meeting the longest idle bursts on both sides.
    initial
    begin
        #10_000_000;
        $display("** dual_pwm_setpoint_panel: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiving side. Outputs are sampled at the rising edge, so they carry
    // the values from just before it. The ready line idles in random bursts,
    // with calm stretches between them, and once in the run it is held low
    // for a long stretch so that the block fills up and refuses input.
    // ------------------------------------------------------------------
    initial
    begin : readout_sink
        int unsigned       stall_left;
        int unsigned       calm_left;
        bit                pressure_done;
        dpsp_pkg::result_t got;
        stall_left    = 0;
        calm_left     = 0;
        pressure_done = 1'b0;
        out_ready    <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready) begin
                got.duty_first       = duty_first;
                got.duty_second      = duty_second;
                got.selected_channel = selected_channel;
                got.digit_value      = digit_value;
                got.digit_position   = digit_position;
                got.digit_strobe     = digit_strobe;
                got.save_first       = save_first;
                got.save_second      = save_second;
                panel_sb.check_readout(got);
                readouts_seen++;
            end
            if (!pressure_done && readouts_seen >= 100) begin
                pressure_done = 1'b1;
                stall_left    = 120;
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (!quiet_run && calm_left == 0 && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(1, 14) - 1;
                if ($urandom_range(0, 3) == 0)
                    calm_left = $urandom_range(20, 60);
                out_ready <= 1'b0;
            end
            else begin
                if (calm_left > 0)
                    calm_left--;
                out_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sending side. Each task is entered and left at a rising edge.
    // ------------------------------------------------------------------

    // Offers one tick word, maybe after an idle burst, and waits until it is
    // taken. Valid stays high across back-to-back words.
    task automatic send_tick(input bit plus_b, input bit minus_b, input bit select_b);
        int unsigned gap;
        if (!quiet_run) begin
            if (send_calm > 0) begin
                send_calm--;
            end
            else if ($urandom_range(0, 4) == 0) begin
                gap = $urandom_range(1, 14);
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
                if ($urandom_range(0, 3) == 0)
                    send_calm = $urandom_range(20, 60);
            end
        end
        in_valid     <= 1'b1;
        plus_level   <= plus_b;
        minus_level  <= minus_b;
        select_level <= select_b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        panel_sb.note_tick(plus_b, minus_b, select_b);
        ticks_sent++;
    endtask

    // Stops offering and waits until every expected readout has arrived;
    // the block is then idle and may be reconfigured.
    task automatic drain_readouts();
        in_valid <= 1'b0;
        while (panel_sb.readout_q.size() != 0) @(posedge clk);
    endtask

    task automatic write_reg(input dpsp_pkg::cfg_index_t idx,
                             input logic [dpsp_pkg::CFG_DAT_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        panel_sb.set_reg(idx, val);
    endtask

    typedef logic [dpsp_pkg::CFG_DAT_W-1:0] cfg_word_t;

    // Writes all four registers back to back, then drops the write enable.
    task automatic apply_settings(input int unsigned limit_d,
                                  input int unsigned first_d,
                                  input int unsigned repeat_d,
                                  input int unsigned frames_d);
        write_reg(dpsp_pkg::CFG_MAX_SETTING,  cfg_word_t'(limit_d));
        write_reg(dpsp_pkg::CFG_FIRST_DELAY,  cfg_word_t'(first_d));
        write_reg(dpsp_pkg::CFG_REPEAT_INTVL, cfg_word_t'(repeat_d));
        write_reg(dpsp_pkg::CFG_FRAMES_DIGIT, cfg_word_t'(frames_d));
        cfg_wr_en <= 1'b0;
    endtask

    // Occasionally sets an ignored button alongside the active one.
    function automatic bit stray_press();
        return ($urandom_range(0, 5) == 0);
    endfunction

    // Random button gestures: mostly press-hold-release of plus or minus and
    // taps of the channel button, with some idle ticks and raw noise mixed in.
    task automatic play_gestures(input int unsigned n_ticks, input int unsigned hold_max);
        int unsigned stop_at;
        int unsigned len;
        int unsigned kind;
        stop_at = ticks_sent + n_ticks;
        while (ticks_sent < stop_at)
        begin
            kind = $urandom_range(0, 9);
            if (kind <= 2) begin
                len = $urandom_range(1, hold_max);
                repeat (len) send_tick(1'b1, stray_press(), stray_press());
                send_tick(1'b0, 1'b0, 1'b0);
            end
            else if (kind <= 5) begin
                len = $urandom_range(1, hold_max);
                repeat (len) send_tick(1'b0, 1'b1, stray_press());
                send_tick(1'b0, 1'b0, 1'b0);
            end
            else if (kind <= 7) begin
                len = $urandom_range(1, 3);
                repeat (len) send_tick(1'b0, 1'b0, 1'b1);
                send_tick(1'b0, 1'b0, 1'b0);
            end
            else if (kind == 8) begin
                len = $urandom_range(1, 5);
                repeat (len) send_tick(1'b0, 1'b0, 1'b0);
            end
            else begin
                len = $urandom_range(1, 8);
                repeat (len) send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                       1'($urandom_range(0, 1)));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial
    begin
        ticks_sent    = 0;
        readouts_seen = 0;
        send_calm     = 0;
        quiet_run     = 1'b0;
        rst_n        <= 1'b0;
        cfg_wr_en    <= 1'b0;
        cfg_index    <= dpsp_pkg::CFG_MAX_SETTING;
        cfg_data     <= '0;
        in_valid     <= 1'b0;
        plus_level   <= 1'b0;
        minus_level  <= 1'b0;
        select_level <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A short spell with the reset defaults in force.
        play_gestures(40, 10);
        drain_readouts();

        // Directed part, with short repeat delays so that auto-repeat shows.
        apply_settings(5, 3, 2, 1);
        send_tick(1'b0, 1'b0, 1'b0);
        send_tick(1'b1, 1'b0, 1'b0);           // plus press steps at once
        repeat (5) send_tick(1'b1, 1'b0, 1'b0); // first delay, then one repeat
        send_tick(1'b0, 1'b0, 1'b0);           // release asks to save channel one
        send_tick(1'b1, 1'b1, 1'b1);           // all three: plus wins
        send_tick(1'b0, 1'b1, 1'b0);           // plus release beats the minus press
        send_tick(1'b0, 1'b1, 1'b0);           // minus press
        send_tick(1'b0, 1'b1, 1'b0);
        send_tick(1'b0, 1'b0, 1'b0);           // minus release
        send_tick(1'b0, 1'b0, 1'b1);           // channel toggles to two
        send_tick(1'b0, 1'b0, 1'b1);           // still held: no second toggle
        send_tick(1'b0, 1'b0, 1'b0);
        send_tick(1'b1, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b0);           // save for channel two
        send_tick(1'b0, 1'b0, 1'b1);           // back to channel one
        send_tick(1'b0, 1'b0, 1'b0);
        drain_readouts();

        // Limit lowered below the current setting: increments are refused,
        // decrements still go through.
        apply_settings(2, 3, 2, 1);
        send_tick(1'b1, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b0);
        send_tick(1'b0, 1'b1, 1'b0);
        send_tick(1'b0, 1'b0, 1'b0);
        drain_readouts();

        // Shortest delays and a digit change on every tick. The long
        // receiver hold-off falls in this phase.
        apply_settings(99, 1, 1, 0);
        play_gestures(100, 30);
        drain_readouts();

        // A limit above 99 lets the tens digit pass nine; a long plus hold
        // drives the selected setting right up to it.
        apply_settings(127, 2, 1, 2);
        repeat (140) send_tick(1'b1, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b0);
        play_gestures(100, 60);
        drain_readouts();

        // Top and bottom extremes: limit zero, longest delays, and a frame
        // count the counter never exceeds, so the readout never alternates.
        apply_settings(0, 32767, 32767, 255);
        play_gestures(80, 20);
        drain_readouts();

        repeat (2)
        begin
            apply_settings($urandom_range(1, 99), $urandom_range(1, 20),
                           $urandom_range(1, 10), $urandom_range(0, 10));
            play_gestures(100, 40);
            drain_readouts();
        end

        // Full-width random data, upper bits included.
        apply_settings($urandom_range(0, 32767), $urandom_range(0, 32767),
                       $urandom_range(0, 32767), $urandom_range(0, 32767));
        play_gestures(80, 20);
        drain_readouts();

        // Closing part at full rate on both sides.
        quiet_run = 1'b1;
        apply_settings(99, 4, 3, 4);
        play_gestures(100, 20);
        drain_readouts();

        // A few more cycles so that any stray readout word is caught.
        repeat (8) @(posedge clk);
        if (panel_sb.mismatches == 0)
            $display("** dual_pwm_setpoint_panel: PASSED **");
        else
            $display("** dual_pwm_setpoint_panel: FAILED **");
        $finish;
    end

endmodule
